[hw/rtl/dlt_pkg.sv]
// dlt_pkg: shared widths and constants for the downlink loss tracker
// used by dlt_div, downlink_loss_tracker_top and the test bench; depends on nothing
`default_nettype none

package dlt_pkg;

	localparam int CNT_W     = 32;   // sequence numbers and counters
	localparam int WIN_W     = 16;   // restart window register
	localparam int SIG_W     = 8;    // signal strength in dBm
	localparam int QUOT_W    = 10;   // delivery ratio in thousandths
	localparam int CNT_IDX_W = $clog2(CNT_W);

	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd100;
	localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_ONE      = {{(CNT_W-1){1'b0}}, 1'b1};

endpackage

`default_nettype wire

[hw/rtl/dlt_div.sv]
// dlt_div: delivery ratio unit, rx * 1000 / (rx + miss) truncated to 10 bits
// restoring division, one quotient bit per cycle; depends on dlt_pkg
`default_nettype none

module dlt_div import dlt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CNT_W-1:0]  rx,
	input  wire logic [CNT_W-1:0]  miss,
	output logic                   done,
	output logic [QUOT_W-1:0]      quot
);

	localparam int NUM_W = CNT_W + QUOT_W;
	localparam int IT_W  = $clog2(QUOT_W);
	localparam logic [IT_W-1:0] IT_LAST = IT_W'(QUOT_W - 1);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_MUL  = 2'd1;
	localparam logic [1:0] D_ITER = 2'd2;

	logic [1:0]        state_q;
	logic [IT_W-1:0]   it_q;
	logic              done_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  den_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W:0]    tot;
	logic [NUM_W:0]    trial;

	// rx + miss at 33 bits, never wraps; rx is at least one after any packet
	assign tot   = {1'b0, rx} + {1'b0, miss};
	assign trial = {1'b0, num_q} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			it_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == D_ITER) && (it_q == IT_LAST);
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					state_q <= D_ITER;
					it_q    <= '0;
				end
				D_ITER: begin
					it_q <= it_q + 1'b1;
					if (it_q == IT_LAST) begin
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// 1000 * rx as (rx << 10) - (rx << 4) - (rx << 3), one subtract a cycle
	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					num_q <= {rx, {QUOT_W{1'b0}}} - {{(QUOT_W-4){1'b0}}, rx, 4'b0};
					den_q <= {tot, {(QUOT_W-1){1'b0}}};
				end
			end
			D_MUL: begin
				num_q <= num_q - {{(QUOT_W-3){1'b0}}, rx, 3'b0};
			end
			D_ITER: begin
				if (!trial[NUM_W]) begin
					num_q <= trial[NUM_W-1:0];
				end
				quot_q <= {quot_q[QUOT_W-2:0], ~trial[NUM_W]};
				den_q  <= {1'b0, den_q[NUM_W-1:1]};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

[hw/rtl/downlink_loss_tracker_top.sv]
// downlink_loss_tracker_top: sequence-number packet loss counter
// bit-serial update of sequence and counters, then dlt_div for the ratio
// depends on dlt_pkg and dlt_div
// steps: input transfer, bit-serial pass, commit, divider start, 1000x scaling,
// 10 divider steps, done flag and output load, after which the result is valid
// a new packet is taken only after the output load of the last; a waiting result does
// not block the next input transfer, only the output load of the packet after it
// reset: arst_n clears all counters, the first-seen flag and the output valid;
// restart window returns to 100
`default_nettype none

module downlink_loss_tracker_top import dlt_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [CNT_W-1:0]         sequence_req,
	input  wire logic signed [SIG_W-1:0]  signal_dbm,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [QUOT_W-1:0]             delivery_permille,
	output logic signed [SIG_W-1:0]       last_signal_dbm,
	output logic [CNT_W-1:0]              received_total,
	output logic [CNT_W-1:0]              missed_total,
	output logic                          fresh_start,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [WIN_W-1:0]         cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SHIFT  = 3'd1;
	localparam logic [2:0] ST_COMMIT = 3'd2;
	localparam logic [2:0] ST_DIVGO  = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	localparam logic [CNT_IDX_W-1:0] BIT_LAST = CNT_IDX_W'(CNT_W - 1);

	logic [2:0]             state_q;
	logic [CNT_IDX_W-1:0]   bit_q;
	logic [WIN_W-1:0]       win_q;

	logic                   seen_q;
	logic [CNT_W-1:0]       last_q;
	logic [CNT_W-1:0]       rx_q;
	logic [CNT_W-1:0]       miss_q;
	logic [SIG_W-1:0]       sig_q;
	logic                   fresh_q;

	logic [CNT_W-1:0]       seq_q;
	logic [CNT_W-1:0]       msum_q;
	logic [CNT_W-1:0]       rxinc_q;
	logic                   cgt_q;
	logic                   cbk_q;
	logic                   bkgt_q;
	logic                   cm_q;
	logic                   cr_q;

	logic                   out_valid_q;
	logic [QUOT_W-1:0]      perm_q;
	logic [SIG_W-1:0]       osig_q;
	logic [CNT_W-1:0]       orx_q;
	logic [CNT_W-1:0]       omiss_q;
	logic                   ofresh_q;

	logic                   in_xfer;
	logic                   out_xfer;
	logic                   out_free;
	logic                   div_start;
	logic                   div_done;
	logic [QUOT_W-1:0]      div_quot;

	logic                   s_b;
	logic                   l_b;
	logic                   w_b;
	logic                   d_b;
	logic                   bk_b;
	logic                   ms_b;
	logic                   ri_b;
	logic                   cgt_nx;
	logic                   cbk_nx;
	logic                   bkgt_nx;
	logic                   cm_nx;
	logic                   cr_nx;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign div_start = (state_q == ST_DIVGO);

	// one bit of each operand per cycle, lsb first
	always_comb begin
		s_b  = seq_q[0];
		l_b  = last_q[0];
		w_b  = bit_q[CNT_IDX_W-1] ? 1'b0 : win_q[bit_q[CNT_IDX_W-2:0]];
		// seq + ~last = seq - last - 1, carry out means seq > last
		d_b    = s_b ^ ~l_b ^ cgt_q;
		cgt_nx = (s_b & ~l_b) | (s_b & cgt_q) | (~l_b & cgt_q);
		// last - seq for the restart check
		bk_b   = l_b ^ ~s_b ^ cbk_q;
		cbk_nx = (l_b & ~s_b) | (l_b & cbk_q) | (~s_b & cbk_q);
		bkgt_nx = (bk_b != w_b) ? (bk_b & ~w_b) : bkgt_q;
		// missed plus gap, and received plus one
		ms_b  = miss_q[0] ^ d_b ^ cm_q;
		cm_nx = (miss_q[0] & d_b) | (miss_q[0] & cm_q) | (d_b & cm_q);
		ri_b  = rx_q[0] ^ cr_q;
		cr_nx = rx_q[0] & cr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			win_q   <= WINDOW_RESET;
			seen_q  <= 1'b0;
			last_q  <= '0;
			rx_q    <= '0;
			miss_q  <= '0;
			sig_q   <= '0;
			fresh_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				win_q <= cfg_data;
			end
			// in ST_EMIT the output register is reloaded instead
			if (out_xfer && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_SHIFT;
						bit_q   <= '0;
						sig_q   <= signal_dbm;
					end
				end
				ST_SHIFT: begin
					last_q <= {l_b, last_q[CNT_W-1:1]};
					rx_q   <= {rx_q[0], rx_q[CNT_W-1:1]};
					miss_q <= {miss_q[0], miss_q[CNT_W-1:1]};
					bit_q  <= bit_q + 1'b1;
					if (bit_q == BIT_LAST) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_DIVGO;
					if (!seen_q || (!cgt_q && bkgt_q)) begin
						// first packet or sender restart
						seen_q  <= 1'b1;
						last_q  <= seq_q;
						rx_q    <= CNT_ONE;
						miss_q  <= '0;
						fresh_q <= 1'b1;
					end else if (cgt_q) begin
						last_q  <= seq_q;
						miss_q  <= cm_q ? CNT_MAX : msum_q;
						rx_q    <= cr_q ? CNT_MAX : rxinc_q;
						fresh_q <= 1'b0;
					end else begin
						rx_q    <= cr_q ? CNT_MAX : rxinc_q;
						fresh_q <= 1'b0;
					end
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// serial datapath and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				seq_q  <= sequence_req;
				cgt_q  <= 1'b0;
				cbk_q  <= 1'b1;
				bkgt_q <= 1'b0;
				cm_q   <= 1'b0;
				cr_q   <= 1'b1;
			end
			ST_SHIFT: begin
				seq_q   <= {s_b, seq_q[CNT_W-1:1]};
				msum_q  <= {ms_b, msum_q[CNT_W-1:1]};
				rxinc_q <= {ri_b, rxinc_q[CNT_W-1:1]};
				cgt_q   <= cgt_nx;
				cbk_q   <= cbk_nx;
				bkgt_q  <= bkgt_nx;
				cm_q    <= cm_nx;
				cr_q    <= cr_nx;
			end
			ST_EMIT: begin
				if (out_free) begin
					perm_q   <= div_quot;
					osig_q   <= sig_q;
					orx_q    <= rx_q;
					omiss_q  <= miss_q;
					ofresh_q <= fresh_q;
				end
			end
			default: ;
		endcase
	end

	dlt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.rx     (rx_q),
		.miss   (miss_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign out_valid         = out_valid_q;
	assign delivery_permille = perm_q;
	assign last_signal_dbm   = osig_q;
	assign received_total    = orx_q;
	assign missed_total      = omiss_q;
	assign fresh_start       = ofresh_q;

	a_accept_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_SHIFT)
		else $error("input transfer did not start the serial pass");

	a_result_counts_packet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> received_total != '0)
		else $error("result with zero received count");

	a_fresh_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fresh_start |-> received_total == CNT_ONE && missed_total == '0)
		else $error("fresh start without reset counts");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> delivery_permille <= QUOT_W'(1000))
		else $error("delivery ratio above 1000");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

[test/downlink_loss_tracker_top_test.sv]
// downlink_loss_tracker_top_test: self-checking bench for the downlink loss tracker
// drives packets and window writes, predicts every ratio report and compares it
// depends on dlt_pkg and downlink_loss_tracker_top
`timescale 1ns / 1ps

module downlink_loss_tracker_top_test;
	import dlt_pkg::*;

	localparam int QUIET_LIMIT  = 3000;
	localparam int SETTLE_TAIL  = 60;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 175;
	localparam int REPORT_LIMIT = 10;
	localparam int ROWS         = 20;

	typedef struct packed {
		logic [QUOT_W-1:0]       permille;
		logic signed [SIG_W-1:0] dbm;
		logic [CNT_W-1:0]        rx;
		logic [CNT_W-1:0]        miss;
		logic                    fresh;
	} ratio_report_t;

	typedef struct packed {
		logic [CNT_W-1:0] seq;
		logic [SIG_W-1:0] dbm;
		logic             typed;
		ratio_report_t    want;
	} packet_row_t;

	// window 100 from reset; typed rows can be read straight off the rules
	localparam packet_row_t DIRECTED_ROWS [ROWS] = '{
		'{32'h0000_0000, 8'h80, 1'b1, '{10'd1000, 8'h80, 32'd1, 32'd0, 1'b1}},
		'{32'h0000_0000, 8'h7F, 1'b1, '{10'd1000, 8'h7F, 32'd2, 32'd0, 1'b0}},
		'{32'hFFFF_FFFF, 8'h00, 1'b1, '{10'd0, 8'h00, 32'd3, 32'hFFFF_FFFE, 1'b0}},
		'{32'hFFFF_FF9B, 8'hFF, 1'b0, '0},
		'{32'hFFFF_FF9A, 8'h01, 1'b1, '{10'd1000, 8'h01, 32'd1, 32'd0, 1'b1}},
		'{32'hFFFF_FF9B, 8'h37, 1'b0, '0},
		'{32'hFFFF_FF9D, 8'hC4, 1'b0, '0},
		'{32'hFFFF_FF9D, 8'h10, 1'b0, '0},
		'{32'hFFFF_FF9C, 8'h20, 1'b0, '0},
		'{32'hFFFF_FF39, 8'hEC, 1'b0, '0},
		'{32'h0000_0000, 8'hD8, 1'b1, '{10'd1000, 8'hD8, 32'd1, 32'd0, 1'b1}},
		'{32'h0000_0001, 8'h40, 1'b0, '0},
		'{32'hAAAA_AAAA, 8'h55, 1'b0, '0},
		'{32'h5555_5555, 8'hAA, 1'b1, '{10'd1000, 8'hAA, 32'd1, 32'd0, 1'b1}},
		'{32'h5555_5556, 8'h80, 1'b0, '0},
		'{32'h8000_0000, 8'h7F, 1'b0, '0},
		'{32'h7FFF_FFFF, 8'h02, 1'b0, '0},
		'{32'h8000_0064, 8'hFE, 1'b0, '0},
		'{32'h8000_0000, 8'h03, 1'b0, '0},
		'{32'h7FFF_FFFF, 8'hFD, 1'b1, '{10'd1000, 8'hFD, 32'd1, 32'd0, 1'b1}}
	};

	logic                    clk;
	logic                    arst_n        = 1'b0;
	logic                    in_valid      = 1'b0;
	logic                    in_stall;
	logic [CNT_W-1:0]        sequence_req  = '0;
	logic signed [SIG_W-1:0] signal_dbm    = '0;
	logic                    out_valid;
	logic                    out_stall     = 1'b0;
	logic [QUOT_W-1:0]       delivery_permille;
	logic signed [SIG_W-1:0] last_signal_dbm;
	logic [CNT_W-1:0]        received_total;
	logic [CNT_W-1:0]        missed_total;
	logic                    fresh_start;
	logic                    cfg_valid     = 1'b0;
	logic                    cfg_ready;
	logic [WIN_W-1:0]        cfg_data      = '0;

	downlink_loss_tracker_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.sequence_req      (sequence_req),
		.signal_dbm        (signal_dbm),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.delivery_permille (delivery_permille),
		.last_signal_dbm   (last_signal_dbm),
		.received_total    (received_total),
		.missed_total      (missed_total),
		.fresh_start       (fresh_start),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data)
	);

	// tracker state as seen by the bench
	logic [WIN_W-1:0] restart_window = WINDOW_RESET;
	logic             seen_flag      = 1'b0;
	logic [CNT_W-1:0] last_seq       = '0;
	logic [CNT_W-1:0] rx_cnt         = '0;
	logic [CNT_W-1:0] miss_cnt       = '0;

	ratio_report_t pending_reports[$];
	int unsigned   mismatch_count = 0;
	int unsigned   feed_idle_pct  = 0;
	int unsigned   drain_idle_pct = 0;
	int unsigned   quiet_cycles   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic ratio_report_t track_packet(input logic [CNT_W-1:0] seq,
			input logic [SIG_W-1:0] dbm);
		ratio_report_t    r;
		logic [CNT_W-1:0] skipped;
		logic [CNT_W:0]   miss_sum;
		logic [63:0]      pool;
		logic [63:0]      quot;
		r.fresh = 1'b0;
		if (!seen_flag || (seq <= last_seq && last_seq - seq > {16'd0, restart_window})) begin
			seen_flag = 1'b1;
			last_seq  = seq;
			rx_cnt    = 32'd1;
			miss_cnt  = '0;
			r.fresh   = 1'b1;
		end else if (seq > last_seq) begin
			skipped  = seq - last_seq - 32'd1;
			miss_sum = {1'b0, miss_cnt} + {1'b0, skipped};
			miss_cnt = miss_sum[CNT_W] ? CNT_MAX : miss_sum[CNT_W-1:0];
			rx_cnt   = (rx_cnt == CNT_MAX) ? CNT_MAX : rx_cnt + 32'd1;
			last_seq = seq;
		end else begin
			rx_cnt = (rx_cnt == CNT_MAX) ? CNT_MAX : rx_cnt + 32'd1;
		end
		// sum held at 64 bits so received plus missed never wraps
		pool = {32'd0, rx_cnt} + {32'd0, miss_cnt};
		quot = (pool == 64'd0) ? 64'd0 : ({32'd0, rx_cnt} * 64'd1000) / pool;
		r.permille = quot[QUOT_W-1:0];
		r.dbm      = dbm;
		r.rx       = rx_cnt;
		r.miss     = miss_cnt;
		return r;
	endfunction

	// mostly a plausible stream around the last sequence, with some noise
	function automatic logic [CNT_W-1:0] pick_sequence();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!seen_flag || roll >= 90)
			return $urandom;
		if (roll < 45)
			return last_seq + $urandom_range(1, 4);
		if (roll < 55)
			return last_seq + $urandom_range(5, 2000);
		if (roll < 63)
			return last_seq;
		if (roll < 73)
			return last_seq - $urandom_range(0, restart_window);
		// straddle the restart boundary
		if (roll < 81)
			return last_seq - restart_window - $urandom_range(0, 1);
		return last_seq - restart_window - 32'd1 - $urandom_range(0, 100000);
	endfunction

	task automatic note_mismatch(input string what, input ratio_report_t want,
			input ratio_report_t got);
		if (mismatch_count < REPORT_LIMIT)
			$display({"%s: expected permille=%0d dbm=%0d rx=%0d miss=%0d fresh=%0d,",
				" got permille=%0d dbm=%0d rx=%0d miss=%0d fresh=%0d"},
				what, want.permille, want.dbm, want.rx, want.miss, want.fresh,
				got.permille, got.dbm, got.rx, got.miss, got.fresh);
		mismatch_count++;
	endtask

	task automatic feed_packet(input logic [CNT_W-1:0] seq, input logic [SIG_W-1:0] dbm,
			input logic typed, input ratio_report_t typed_want);
		ratio_report_t want;
		while ($urandom_range(0, 99) < feed_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sequence_req <= seq;
		signal_dbm   <= dbm;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = track_packet(seq, dbm);
		if (typed)
			want = typed_want;
		pending_reports.push_back(want);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid      <= 1'b0;
		restart_window = value;
	endtask

	task automatic wait_drained();
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// result check and receiver stall
	always @(posedge clk) begin
		ratio_report_t got;
		ratio_report_t want;
		if (out_valid && !out_stall) begin
			got = {delivery_permille, last_signal_dbm, received_total, missed_total,
				fresh_start};
			if (pending_reports.size() == 0) begin
				note_mismatch("result with nothing pending", '0, got);
			end else begin
				want = pending_reports.pop_front();
				if (got.permille !== want.permille || got.dbm !== want.dbm ||
						got.rx !== want.rx || got.miss !== want.miss ||
						got.fresh !== want.fresh)
					note_mismatch("report mismatch", want, got);
			end
		end
		out_stall <= ($urandom_range(0, 99) < drain_idle_pct);
	end

	// watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("downlink_loss_tracker_top_test failed");
			$finish;
		end
	end

	initial begin
		logic [WIN_W-1:0] window_plan [PHASES];
		logic [CNT_W-1:0] seq;
		window_plan[0] = '0;
		window_plan[1] = '1;
		window_plan[2] = WIN_W'($urandom_range(0, 65535));
		window_plan[3] = 16'd1;
		window_plan[4] = WIN_W'($urandom_range(0, 300));
		window_plan[5] = WINDOW_RESET;

		feed_idle_pct  = 21;
		drain_idle_pct = 73;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ROWS; i++)
			feed_packet(DIRECTED_ROWS[i].seq, DIRECTED_ROWS[i].dbm, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].want);

		for (int p = 0; p < PHASES; p++) begin
			in_valid <= 1'b0;
			if (p == 2) begin
				feed_idle_pct  = 73;
				drain_idle_pct = 21;
			end else if (p == 4) begin
				feed_idle_pct  = 0;
				drain_idle_pct = 0;
			end
			wait_drained();
			write_window(window_plan[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				seq = pick_sequence();
				feed_packet(seq, SIG_W'($urandom), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (SETTLE_TAIL) @(posedge clk);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("downlink_loss_tracker_top_test passed");
		else
			$display("downlink_loss_tracker_top_test failed");
		$finish;
	end

endmodule

[downlink_loss_tracker_top.f]
hw/rtl/dlt_pkg.sv
hw/rtl/dlt_div.sv
hw/rtl/downlink_loss_tracker_top.sv
test/downlink_loss_tracker_top_test.sv
